/* rtl/core/dual_band_biquad_tone_detector_defines.svh */
// ----------------------------------------------------------------------------
// Dual band tone detector assertion macros
// Shared concurrent assertion forms for the checker of the tone detector.
// ----------------------------------------------------------------------------
`ifndef DUAL_BAND_BIQUAD_TONE_DETECTOR_DEFINES_SVH
`define DUAL_BAND_BIQUAD_TONE_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/dbtd_pkg.sv */
// ----------------------------------------------------------------------------
// Dual band tone detector package
// Widths, filter coefficients and control structures shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package dbtd_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int Y_W        = 32;
	localparam int D_W        = 33;
	localparam int COEF_W     = 19;
	localparam int PROD_W     = D_W + COEF_W;
	localparam int ACC_W      = PROD_W + 1;
	localparam int MAG_W      = ACC_W - 1;
	localparam int DIGIT_W    = 4;
	localparam int DIGITS     = MAG_W / DIGIT_W;
	localparam int REM_W      = 17;
	localparam int STEP_W     = REM_W + DIGIT_W;
	localparam int CNT_W      = $clog2(DIGITS + 1);
	localparam int PEAK_W     = 31;
	localparam int THR_W      = 31;
	localparam int DEC_W      = 16;
	localparam int NUM_BANDS  = 2;
	localparam int NUM_STAGES = 4;

	localparam int COEF_SCALE = 100000;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1000);

	localparam int WINDOW_LENGTH_DEF   = 20;
	localparam int DECISION_PERIOD_DEF = 15;

	// Stage index of the job that scales the last stage output.
	localparam logic [2:0] FINAL_JOB = 3'(NUM_STAGES);

	localparam logic [1:0] TERM_X  = 2'd0;
	localparam logic [1:0] TERM_Y1 = 2'd1;
	localparam logic [1:0] TERM_Y2 = 2'd2;

	// Feedback coefficients are stored negated so that every term is added.
	localparam logic signed [COEF_W-1:0] A1N [NUM_BANDS][NUM_STAGES] = '{
		'{19'sd184923, 19'sd185935, 19'sd184491, 19'sd184919},
		'{19'sd177777, 19'sd179266, 19'sd177360, 19'sd177985}
	};
	localparam logic signed [COEF_W-1:0] A2N [NUM_BANDS][NUM_STAGES] = '{
		'{-19'sd99430, -19'sd99449, -19'sd98644, -19'sd98663},
		'{-19'sd99304, -19'sd99327, -19'sd98345, -19'sd98368}
	};
	localparam logic signed [COEF_W-1:0] GAIN [NUM_BANDS][NUM_STAGES] = '{
		'{19'sd731, 19'sd731, 19'sd728, 19'sd728},
		'{19'sd893, 19'sd893, 19'sd889, 19'sd889}
	};

	typedef struct packed {
		logic mul;
		logic clr;
		logic div;
	} alu_ctrl_t;

	typedef struct packed {
		logic busy;
	} alu_stat_t;

	typedef struct packed {
		logic push;
		logic scan;
	} win_ctrl_t;

	typedef struct packed {
		logic done;
	} win_stat_t;

	// The numerator 100000*(u0-u2) of later stages, scaled by g and divided by
	// 100000, is exactly (u0-u2)*g, so only the first stage keeps the scale.
	function automatic logic signed [COEF_W-1:0] coef_of(input logic band,
		input logic [2:0] stage, input logic [1:0] term);
		logic signed [COEF_W-1:0] c;
		logic [1:0] idx;
		c   = '0;
		idx = stage[1:0];
		if (stage == FINAL_JOB) begin
			if (term == TERM_X)
				c = GAIN[band][NUM_STAGES-1];
		end else begin
			case (term)
				TERM_X: begin
					if (stage == 3'd0)
						c = COEF_W'(COEF_SCALE);
					else
						c = GAIN[band][idx - 2'd1];
				end
				TERM_Y1: c = A1N[band][idx];
				TERM_Y2: c = A2N[band][idx];
				default: c = '0;
			endcase
		end
		return c;
	endfunction

	function automatic logic [STEP_W-1:0] digit_mult(input logic [DIGIT_W-1:0] k);
		return STEP_W'(k) * STEP_W'(COEF_SCALE);
	endfunction

endpackage

`default_nettype wire

/* rtl/core/dbtd_if.sv */
// ----------------------------------------------------------------------------
// Dual band tone detector channels
// Valid/ready interfaces for the sample stream and the decision stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbtd_sample_if;
	logic valid;
	logic ready;
	logic signed [dbtd_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface dbtd_result_if;
	logic valid;
	logic ready;
	logic low_tone_detected;
	logic high_tone_detected;
	logic [dbtd_pkg::PEAK_W-1:0] low_band_peak;
	logic [dbtd_pkg::PEAK_W-1:0] high_band_peak;
	logic [dbtd_pkg::DEC_W-1:0] decision_number;

	modport source (output valid, output low_tone_detected, output high_tone_detected,
		output low_band_peak, output high_band_peak, output decision_number, input ready);
	modport sink (input valid, input low_tone_detected, input high_tone_detected,
		input low_band_peak, input high_band_peak, input decision_number, output ready);
endinterface

`default_nettype wire

/* rtl/core/dbtd_alu.sv */
// ----------------------------------------------------------------------------
// Dual band tone detector arithmetic unit
// Shared multiply-accumulate and a radix-16 divider by the coefficient scale.
// ----------------------------------------------------------------------------
`default_nettype none

module dbtd_alu (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire dbtd_pkg::alu_ctrl_t                ctrl,
	input  wire logic signed [dbtd_pkg::COEF_W-1:0] coef,
	input  wire logic signed [dbtd_pkg::D_W-1:0]    opnd,
	output dbtd_pkg::alu_stat_t                     stat,
	output logic signed [dbtd_pkg::Y_W-1:0]         quo
);
	import dbtd_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     prod_vld_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic [MAG_W-1:0]         mag_q;
	logic [REM_W-1:0]         rem_q;
	logic                     neg_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;

	logic [STEP_W-1:0]  step_val;
	logic [14:0]        ge;
	logic [DIGIT_W-1:0] digit;
	logic [STEP_W-1:0]  step_rem;
	logic [ACC_W-1:0]   acc_abs;
	logic [Y_W-1:0]     quo_mag;

	// One quotient digit per cycle: the remainder stays below the divisor.
	always_comb begin
		step_val = {rem_q, mag_q[MAG_W-1 -: DIGIT_W]};
		for (int k = 1; k < 16; k++)
			ge[k-1] = step_val >= digit_mult(DIGIT_W'(k));
		digit    = DIGIT_W'($countones(ge));
		step_rem = step_val - digit_mult(digit);
		acc_abs  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		quo_mag  = mag_q[Y_W-1:0];
		quo      = neg_q ? Y_W'(-quo_mag) : Y_W'(quo_mag);
		stat.busy = busy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
			acc_q       <= '0;
			busy_q      <= 1'b0;
			cnt_q       <= '0;
		end else begin
			prod_vld_s1 <= ctrl.mul;
			if (ctrl.clr)
				acc_q <= '0;
			else if (prod_vld_s1)
				acc_q <= acc_q + ACC_W'(prod_s1);
			if (ctrl.div) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIGITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul)
			prod_s1 <= coef * opnd;
		if (ctrl.div) begin
			neg_q <= acc_q[ACC_W-1];
			mag_q <= acc_abs[MAG_W-1:0];
			rem_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[MAG_W-DIGIT_W-1:0], digit};
			rem_q <= step_rem[REM_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/dbtd_window.sv */
// ----------------------------------------------------------------------------
// Dual band tone detector window store
// Circular buffers of recent band outputs and a sequential peak scan.
// ----------------------------------------------------------------------------
`default_nettype none

module dbtd_window #(
	parameter int WINDOW_LENGTH = dbtd_pkg::WINDOW_LENGTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire dbtd_pkg::win_ctrl_t               ctrl,
	input  wire logic signed [dbtd_pkg::Y_W-1:0]   lo_data,
	input  wire logic signed [dbtd_pkg::Y_W-1:0]   hi_data,
	output dbtd_pkg::win_stat_t                    stat,
	output logic [dbtd_pkg::PEAK_W-1:0]            lo_peak,
	output logic [dbtd_pkg::PEAK_W-1:0]            hi_peak
);
	import dbtd_pkg::*;

	localparam int AW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(WINDOW_LENGTH - 1);

	logic signed [Y_W-1:0] mem_lo [WINDOW_LENGTH];
	logic signed [Y_W-1:0] mem_hi [WINDOW_LENGTH];
	logic [WINDOW_LENGTH-1:0] valid_q;
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic          scan_q;
	logic          take_s1;
	logic          last_s1;
	logic          vld_s1;
	logic signed [Y_W-1:0] lo_s1;
	logic signed [Y_W-1:0] hi_s1;
	logic [Y_W-1:0] lo_peak_q;
	logic [Y_W-1:0] hi_peak_q;
	logic           done_q;
	logic [Y_W-1:0] lo_mag;
	logic [Y_W-1:0] hi_mag;

	// An entry never written since reset counts as zero.
	always_comb begin
		lo_mag = '0;
		hi_mag = '0;
		if (vld_s1) begin
			lo_mag = lo_s1[Y_W-1] ? Y_W'(-lo_s1) : Y_W'(lo_s1);
			hi_mag = hi_s1[Y_W-1] ? Y_W'(-hi_s1) : Y_W'(hi_s1);
		end
		lo_peak = lo_peak_q[Y_W-1] ? {PEAK_W{1'b1}} : lo_peak_q[PEAK_W-1:0];
		hi_peak = hi_peak_q[Y_W-1] ? {PEAK_W{1'b1}} : hi_peak_q[PEAK_W-1:0];
		stat.done = done_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem_lo[wr_ptr_q] <= lo_data;
			mem_hi[wr_ptr_q] <= hi_data;
		end
		lo_s1 <= mem_lo[rd_ptr_q];
		hi_s1 <= mem_hi[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			scan_q    <= 1'b0;
			take_s1   <= 1'b0;
			last_s1   <= 1'b0;
			vld_s1    <= 1'b0;
			lo_peak_q <= '0;
			hi_peak_q <= '0;
			done_q    <= 1'b0;
		end else begin
			if (ctrl.push) begin
				valid_q[wr_ptr_q] <= 1'b1;
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			take_s1 <= scan_q;
			last_s1 <= scan_q && (rd_ptr_q == LAST);
			vld_s1  <= scan_q && valid_q[rd_ptr_q];
			if (ctrl.scan) begin
				scan_q    <= 1'b1;
				rd_ptr_q  <= '0;
				lo_peak_q <= '0;
				hi_peak_q <= '0;
			end else begin
				if (scan_q) begin
					rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
					if (rd_ptr_q == LAST)
						scan_q <= 1'b0;
				end
				if (take_s1) begin
					if (lo_mag > lo_peak_q)
						lo_peak_q <= lo_mag;
					if (hi_mag > hi_peak_q)
						hi_peak_q <= hi_mag;
				end
			end
			done_q <= take_s1 && last_s1;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/dual_band_biquad_tone_detector.sv */
// ----------------------------------------------------------------------------
// Dual band tone detector
// Two four-stage bandpass cascades on one shared unit, with windowed peaks.
// ----------------------------------------------------------------------------
// Each sample runs through ten jobs on one shared multiply-accumulate and
// divide unit: four biquad stages and an output scaling for the low band,
// then the same for the high band. A job runs three products, a drain
// state, a start state, radix-16 division by 100000 and a write-back,
// and the input is not ready while a sample is processed. On a decision
// sample the window scan follows and the result then waits in the output
// register; the next sample may be taken while it waits.
// `default_nettype none follows.
`default_nettype none

module dual_band_biquad_tone_detector #(
	parameter int WINDOW_LENGTH   = dbtd_pkg::WINDOW_LENGTH_DEF,
	parameter int DECISION_PERIOD = dbtd_pkg::DECISION_PERIOD_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [dbtd_pkg::THR_W-1:0]    cfg_wdata,
	dbtd_sample_if.sink                        samples,
	dbtd_result_if.source                      results
);
	import dbtd_pkg::*;

	localparam int PW = (DECISION_PERIOD > 1) ? $clog2(DECISION_PERIOD) : 1;
	localparam logic [PW-1:0] PHASE_LAST = PW'(DECISION_PERIOD - 1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MUL   = 8'b0000_0010,
		S_DRAIN = 8'b0000_0100,
		S_DIVST = 8'b0000_1000,
		S_DIV   = 8'b0001_0000,
		S_WB    = 8'b0010_0000,
		S_SCAN  = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [THR_W-1:0] thr_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SAMPLE_W-1:0] xh1_q;
	logic signed [SAMPLE_W-1:0] xh2_q;
	logic signed [Y_W-1:0] y1_q [NUM_BANDS][NUM_STAGES];
	logic signed [Y_W-1:0] y2_q [NUM_BANDS][NUM_STAGES];
	logic signed [D_W-1:0] d_q;
	logic signed [Y_W-1:0] v_q;
	logic signed [Y_W-1:0] lo_q;
	logic       band_q;
	logic [2:0] stage_q;
	logic [1:0] term_q;
	logic [PW-1:0] phase_q;
	logic [DEC_W-1:0] dec_q;
	logic out_valid_q;
	logic out_lo_det_q;
	logic out_hi_det_q;
	logic [PEAK_W-1:0] out_lo_peak_q;
	logic [PEAK_W-1:0] out_hi_peak_q;
	logic [DEC_W-1:0]  out_dec_q;

	alu_ctrl_t alu_ctrl;
	alu_stat_t alu_stat;
	win_ctrl_t win_ctrl;
	win_stat_t win_stat;
	logic signed [COEF_W-1:0] coef;
	logic signed [D_W-1:0]    opnd;
	logic signed [Y_W-1:0]    quo;
	logic signed [Y_W-1:0]    y1_sel;
	logic signed [Y_W-1:0]    y2_sel;
	logic [PEAK_W-1:0] lo_peak;
	logic [PEAK_W-1:0] hi_peak;
	logic last_job;
	logic out_free;

	assign samples.ready = (state_q == S_IDLE);
	assign results.valid = out_valid_q;
	assign results.low_tone_detected  = out_lo_det_q;
	assign results.high_tone_detected = out_hi_det_q;
	assign results.low_band_peak      = out_lo_peak_q;
	assign results.high_band_peak     = out_hi_peak_q;
	assign results.decision_number    = out_dec_q;

	always_comb begin
		y1_sel   = y1_q[band_q][stage_q[1:0]];
		y2_sel   = y2_q[band_q][stage_q[1:0]];
		coef     = coef_of(band_q, stage_q, term_q);
		last_job = (stage_q == FINAL_JOB) && band_q;
		out_free = !out_valid_q || results.ready;
		case (term_q)
			TERM_X:  opnd = (stage_q == FINAL_JOB) ? D_W'(v_q) : d_q;
			TERM_Y1: opnd = D_W'(y1_sel);
			TERM_Y2: opnd = D_W'(y2_sel);
			default: opnd = '0;
		endcase
		alu_ctrl.mul = (state_q == S_MUL);
		alu_ctrl.clr = (state_q == S_MUL) && (term_q == TERM_X);
		alu_ctrl.div = (state_q == S_DIVST);
		win_ctrl.push = (state_q == S_WB) && last_job;
		win_ctrl.scan = win_ctrl.push && (phase_q == '0);
	end

	dbtd_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (alu_ctrl),
		.coef   (coef),
		.opnd   (opnd),
		.stat   (alu_stat),
		.quo    (quo)
	);

	dbtd_window #(
		.WINDOW_LENGTH (WINDOW_LENGTH)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (win_ctrl),
		.lo_data (lo_q),
		.hi_data (quo),
		.stat    (win_stat),
		.lo_peak (lo_peak),
		.hi_peak (hi_peak)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			thr_q   <= THR_RESET;
			xh1_q   <= '0;
			xh2_q   <= '0;
			for (int b = 0; b < NUM_BANDS; b++) begin
				for (int s = 0; s < NUM_STAGES; s++) begin
					y1_q[b][s] <= '0;
					y2_q[b][s] <= '0;
				end
			end
			band_q      <= 1'b0;
			stage_q     <= '0;
			term_q      <= TERM_X;
			phase_q     <= '0;
			dec_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				thr_q <= cfg_wdata;
			if (state_q == S_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (samples.valid) begin
						band_q  <= 1'b0;
						stage_q <= '0;
						term_q  <= TERM_X;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					term_q <= term_q + 1'b1;
					if (term_q == TERM_Y2)
						state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_DIVST;
				S_DIVST: state_q <= S_DIV;
				S_DIV: begin
					if (!alu_stat.busy)
						state_q <= S_WB;
				end
				S_WB: begin
					term_q <= TERM_X;
					if (stage_q != FINAL_JOB) begin
						y1_q[band_q][stage_q[1:0]] <= quo;
						y2_q[band_q][stage_q[1:0]] <= y1_sel;
						stage_q <= stage_q + 1'b1;
						state_q <= S_MUL;
					end else if (!band_q) begin
						band_q  <= 1'b1;
						stage_q <= '0;
						state_q <= S_MUL;
					end else begin
						xh2_q   <= xh1_q;
						xh1_q   <= sample_q;
						phase_q <= (phase_q == PHASE_LAST) ? '0 : phase_q + 1'b1;
						state_q <= (phase_q == '0) ? S_SCAN : S_IDLE;
					end
				end
				S_SCAN: begin
					if (win_stat.done)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						dec_q   <= dec_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Operand and result registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && samples.valid) begin
			sample_q <= samples.sample;
			d_q      <= D_W'(samples.sample) - D_W'(xh2_q);
		end
		if (state_q == S_WB) begin
			if (stage_q != FINAL_JOB) begin
				// The next stage sees this output and the one from two samples ago.
				d_q <= D_W'(quo) - D_W'(y2_sel);
				v_q <= quo;
			end else if (!band_q) begin
				lo_q <= quo;
				d_q  <= D_W'(sample_q) - D_W'(xh2_q);
			end
		end
		if (state_q == S_EMIT && out_free) begin
			out_lo_det_q  <= lo_peak > thr_q;
			out_hi_det_q  <= hi_peak > thr_q;
			out_lo_peak_q <= lo_peak;
			out_hi_peak_q <= hi_peak;
			out_dec_q     <= dec_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/dbtd_checker.sv */
// ----------------------------------------------------------------------------
// Dual band tone detector checker
// Port-level assertions on the tone detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_band_biquad_tone_detector_defines.svh"

module dbtd_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [dbtd_pkg::DEC_W-1:0]   out_number
);
	import dbtd_pkg::*;

	logic [DEC_W-1:0] expect_num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			expect_num_q <= '0;
		else if (out_valid && out_ready)
			expect_num_q <= expect_num_q + 1'b1;
	end

	// A sample takes many cycles, so the input closes after each transaction.
	`DBTD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "input ready after accepted sample")

	// Decisions are numbered consecutively from zero.
	`DBTD_ASSERT_NOW(a_decision_sequence, clk, arst_n, out_valid, out_number == expect_num_q, "decision number out of sequence")

	`DBTD_ASSERT_NEXT(a_result_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_number), "stalled result changed")

endmodule

bind dual_band_biquad_tone_detector dbtd_checker u_dbtd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_number (results.decision_number)
);

`default_nettype wire
